// ----- src/ncpm_pkg.sv -----
// Shared constants and types for the negacyclic polynomial multiplier core.
// Holds no logic and depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ncpm_pkg;

    // Widths of the fixed request fields and of the modulus register.
    localparam int FUNC_W  = 1;
    localparam int INDEX_W = 8;
    localparam int COEFF_W = 16;
    localparam int MOD_W   = 15;

    // Product of two signed coefficients.
    localparam int PROD_W = 2 * COEFF_W;

    // Number of entries that a load request can reach.
    localparam int INDEX_SPAN = 1 << INDEX_W;

    // Function codes of a request.
    localparam logic [FUNC_W-1:0] FUNC_LOAD = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_PROD = 1'b1;

    // Modulus after reset, and the smallest modulus the datapath uses.
    localparam logic [MOD_W-1:0] MOD_RESET = 15'd3329;
    localparam logic [MOD_W-1:0] MOD_MIN   = 15'd2;

    typedef logic signed [COEFF_W-1:0] t_coeff;
    typedef logic signed [PROD_W-1:0]  t_prod;

endpackage

`default_nettype wire

// ----- src/negacyclic_poly_mul_mod_q_core.sv -----
// Top level of the negacyclic schoolbook polynomial multiplier modulo (x^N + 1, q).
// Uses ncpm_pkg for field widths, function codes and the modulus reset value.
`timescale 1ns / 1ps
`default_nettype none

// A load request (func 0) writes one coefficient of each operand at index, and
// the core is ready again right away. A product request (func 1) runs the
// multiply-accumulate walk, where a single 16x16 multiplier visits every
// stored coefficient pair once, then a bit-serial remainder unit over the
// ACC_W = 32 + clog2(DEGREE) accumulator bits, then a lift step that brings
// the residue into 0..q-1. The input stall stays high for the whole product
// request. A finished coefficient sits in an output register, so loads are
// taken while it waits. A product request at an index of DEGREE or above
// returns 0. The modulus register is written through its own port; values 0
// and 1 act as 2.
module negacyclic_poly_mul_mod_q_core
    import ncpm_pkg::*;
#(
    parameter int DEGREE = 256
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    // Request channel
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire  [FUNC_W-1:0]        i_func,
    input  wire  [INDEX_W-1:0]       i_index,
    input  wire  signed [COEFF_W-1:0] i_coeff_a,
    input  wire  signed [COEFF_W-1:0] i_coeff_b,
    // Result channel
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output logic [MOD_W-1:0]         o_product_coeff,
    // Modulus write channel
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire  [MOD_W-1:0]         i_cfg_modulus
);

    localparam int AW    = (DEGREE > 1) ? $clog2(DEGREE) : 1;
    localparam int ACC_W = PROD_W + AW;
    localparam int CNT_W = $clog2(ACC_W + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_FIX   = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [MOD_W-1:0]   r_mod;
    logic [MOD_W-1:0]   q_eff;

    logic [AW-1:0]      r_i;
    logic [AW-1:0]      r_j;
    logic [AW:0]        k_diff;
    logic [AW-1:0]      k_addr;
    logic               k_wrap;
    logic               pair_zero;

    t_coeff             mem_a [DEGREE];
    t_coeff             mem_b [DEGREE];
    t_coeff             r_rd_a, r_rd_b;
    logic               r_p1_vld, r_p1_neg, r_p1_zero;
    t_prod              r_prod;
    logic               r_p2_vld, r_p2_neg;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] prod_ext;

    logic [ACC_W-1:0]   r_mag;
    logic [MOD_W-1:0]   r_rem;
    logic               r_res_neg;
    logic [CNT_W-1:0]   r_cnt;
    logic [MOD_W:0]     div_trial;
    logic [MOD_W:0]     div_sub;
    logic [MOD_W-1:0]   fix_val;

    logic               in_acc;
    logic               in_range;
    logic               load_we;
    logic               out_free;
    logic               last_j;

    // Handshakes and request decode.
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign in_range    = (int'(i_index) < DEGREE);
    assign load_we     = in_acc && (i_func == FUNC_LOAD) && in_range;
    assign out_free    = !o_out_valid || !i_out_stall;
    assign last_j      = (r_j == AW'(DEGREE - 1));

    // Effective modulus: values below two act as two.
    assign q_eff = (r_mod < MOD_MIN) ? MOD_MIN : r_mod;

    // Modulus register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mod <= i_cfg_modulus;
        end
    end

    // Partner address: i - j, wrapping by DEGREE with a sign flip when j > i.
    assign k_diff    = {1'b0, r_i} - {1'b0, r_j};
    assign k_wrap    = (r_j > r_i);
    assign k_addr    = k_wrap ? AW'(k_diff + (AW+1)'(DEGREE)) : k_diff[AW-1:0];
    // Entries beyond the reach of the index field always read as zero.
    assign pair_zero = (int'(r_j) >= INDEX_SPAN) || (int'(k_addr) >= INDEX_SPAN);

    // Coefficient stores: one write port for loads, one registered read each.
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            mem_a[AW'(i_index)] <= t_coeff'(i_coeff_a);
            mem_b[AW'(i_index)] <= t_coeff'(i_coeff_b);
        end
        r_rd_a <= mem_a[r_j];
        r_rd_b <= mem_b[k_addr];
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_func == FUNC_PROD)) begin
                    n_state = in_range ? ST_MAC : ST_FIX;
                end
            end
            ST_MAC: begin
                if (last_j) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_p1_vld && !r_p2_vld) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers: state, pair counter and pipeline valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_j      <= '0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= (r_state == ST_MAC);
            r_p2_vld <= r_p1_vld;
            if (r_state == ST_IDLE) begin
                r_j <= '0;
            end else if (r_state == ST_MAC) begin
                r_j <= r_j + AW'(1);
            end
        end
    end

    // Multiply-accumulate pipeline: read, multiply, then add or subtract.
    assign prod_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        r_p1_neg  <= k_wrap;
        r_p1_zero <= pair_zero;
        r_prod    <= r_p1_zero ? t_prod'(0) : (t_prod'(r_rd_a) * t_prod'(r_rd_b));
        r_p2_neg  <= r_p1_neg;
        if (in_acc) begin
            r_i   <= AW'(i_index);
            r_acc <= '0;
        end else if (r_p2_vld) begin
            r_acc <= r_p2_neg ? (r_acc - prod_ext) : (r_acc + prod_ext);
        end
    end

    // Bit-serial remainder of the accumulator magnitude by the modulus.
    assign div_trial = {r_rem, r_mag[ACC_W-1]};
    assign div_sub   = div_trial - {1'b0, q_eff};

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rem     <= '0;
            r_res_neg <= 1'b0;
        end else if ((r_state == ST_DRAIN) && !r_p1_vld && !r_p2_vld) begin
            r_rem     <= '0;
            r_res_neg <= r_acc[ACC_W-1];
            r_mag     <= r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
            r_cnt     <= CNT_W'(ACC_W);
        end else if (r_state == ST_DIV) begin
            r_rem <= (div_trial >= {1'b0, q_eff}) ? div_sub[MOD_W-1:0]
                                                  : div_trial[MOD_W-1:0];
            r_mag <= r_mag << 1;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Lift a negative sum's residue into 0..q-1.
    assign fix_val = (r_res_neg && (r_rem != '0)) ? (q_eff - r_rem) : r_rem;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if ((r_state == ST_FIX) && out_free) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIX) && out_free) begin
            o_product_coeff <= fix_val;
        end
    end

    // A result only appears after the lift step.
    a_out_from_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_FIX))
        else $error("result register loaded outside the lift step");

    // The running remainder stays below the modulus.
    a_rem_below_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < q_eff))
        else $error("remainder reached the modulus");

    // An in-range product request starts the multiply-accumulate walk.
    a_req_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_func == FUNC_PROD) && in_range) |=>
            ((r_state == ST_MAC) && (r_j == '0)))
        else $error("product request did not start the walk");

    // The multiplier pipeline is empty whenever the core is idle.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_IDLE) && $past(r_state == ST_IDLE)) |->
            (!r_p1_vld && !r_p2_vld))
        else $error("pipeline busy while idle");

endmodule

`default_nettype wire

// ----- test/tb_negacyclic_poly_mul_mod_q_core.sv -----
// Self-checking testbench for negacyclic_poly_mul_mod_q_core: loads coefficient pairs,
// requests product coefficients under several moduli and checks each result in order.
// Depends on ncpm_pkg and the core; the expected coefficients come from an in-bench model.
`timescale 1ns / 1ps

module tb_negacyclic_poly_mul_mod_q_core;
    import ncpm_pkg::*;

    localparam int DEGREE = 256;
    // Product walk plus the bit-serial remainder and the final lift, with margin.
    localparam int DRAIN_CYCLES = DEGREE + 3 + 32 + $clog2(DEGREE) + 1 + 40;
    localparam int PHASE_REQUESTS = 200;
    localparam t_coeff COEFF_MIN = 16'sh8000;
    localparam t_coeff COEFF_MAX = 16'sh7FFF;
    localparam logic [MOD_W-1:0] MOD_MAX = '1;

    // Holds both operand polynomials and the modulus, and queues the product
    // coefficients that the core still owes.
    class poly_product_board;
        t_coeff poly_a [DEGREE];
        t_coeff poly_b [DEGREE];
        logic [MOD_W-1:0] modulus;
        logic [MOD_W-1:0] expected_coeffs [$];
        int mismatch_count;

        function new();
            modulus = MOD_RESET;
            mismatch_count = 0;
        endfunction

        function void set_modulus(logic [MOD_W-1:0] value);
            modulus = value;
        endfunction

        function int pending();
            return expected_coeffs.size();
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            mismatch_count++;
        endtask

        // Negacyclic coefficient i, with every product and partial sum reduced by a
        // remainder that truncates toward zero, then lifted into 0..q-1.
        function logic [MOD_W-1:0] negacyclic_coeff(int i);
            longint q;
            longint pos;
            longint neg;
            longint p;
            longint diff;
            q = (modulus < MOD_MIN) ? longint'(MOD_MIN) : longint'(modulus);
            pos = 0;
            neg = 0;
            for (int j = 0; j < DEGREE; j++) begin
                if (j <= i) begin
                    p = longint'(poly_a[j]) * longint'(poly_b[i - j]);
                    pos = (pos + p % q) % q;
                end else begin
                    p = longint'(poly_a[j]) * longint'(poly_b[DEGREE + i - j]);
                    neg = (neg + p % q) % q;
                end
            end
            diff = (pos - neg) % q;
            if (diff < 0) begin
                diff += q;
            end
            return diff[MOD_W-1:0];
        endfunction

        // Called for every accepted request: a load updates the operands, a
        // product request queues the coefficient it must return.
        function void note_request(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] index,
                                   t_coeff a, t_coeff b);
            if (func == FUNC_LOAD) begin
                if (int'(index) < DEGREE) begin
                    poly_a[index] = a;
                    poly_b[index] = b;
                end
            end else begin
                expected_coeffs.push_back((int'(index) < DEGREE) ?
                                          negacyclic_coeff(int'(index)) : '0);
            end
        endfunction

        task check_coeff(logic [MOD_W-1:0] got);
            logic [MOD_W-1:0] want;
            if (expected_coeffs.size() == 0) begin
                report_mismatch($sformatf("product coeff %0d with no request pending", got));
            end else begin
                want = expected_coeffs.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("product coeff got %0d expected %0d", got, want));
                end
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic [FUNC_W-1:0] i_func = FUNC_LOAD;
    logic [INDEX_W-1:0] i_index = '0;
    t_coeff i_coeff_a = '0;
    t_coeff i_coeff_b = '0;
    logic i_out_stall = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [MOD_W-1:0] i_cfg_modulus = MOD_RESET;
    logic o_in_stall;
    logic o_out_valid;
    logic [MOD_W-1:0] o_product_coeff;
    logic o_cfg_ready;

    // Set for one whole phase so that neither side idles.
    logic quiet = 1'b0;

    poly_product_board board;

    negacyclic_poly_mul_mod_q_core #(
        .DEGREE(DEGREE)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_func(i_func),
        .i_index(i_index),
        .i_coeff_a(i_coeff_a),
        .i_coeff_b(i_coeff_b),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_product_coeff(o_product_coeff),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_modulus(i_cfg_modulus)
    );

    always #2 i_clk = ~i_clk;

    // The result side stalls at random unless the quiet phase is running.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(99) < 21);
        end
    end

    // Track accepted requests, modulus writes and results at each rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                board.note_request(i_func, i_index, i_coeff_a, i_coeff_b);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                board.set_modulus(i_cfg_modulus);
            end
            if (o_out_valid && !i_out_stall) begin
                board.check_coeff(o_product_coeff);
            end
        end
    end

    // Mostly random values, with the signed extremes and zero mixed in.
    function automatic t_coeff rand_coeff();
        case ($urandom_range(9))
            0: return COEFF_MIN;
            1: return COEFF_MAX;
            2: return '0;
            default: return t_coeff'($urandom);
        endcase
    endfunction

    // Present one request, after a random idle gap, and hold it until accepted.
    task automatic send_request(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] index,
                                t_coeff a, t_coeff b);
        if (!quiet && $urandom_range(99) < 21) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 21) begin
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_func <= func;
        i_index <= index;
        i_coeff_a <= a;
        i_coeff_b <= b;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every queued coefficient has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (board.pending() != 0);
    endtask

    // Write the modulus once the core is idle, letting a trailing load finish first.
    task automatic change_modulus(logic [MOD_W-1:0] value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_modulus <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [MOD_W-1:0] phase_modulus;
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every entry of both operands before any product is requested.
        for (int k = 0; k < DEGREE; k++) begin
            send_request(FUNC_LOAD, k[INDEX_W-1:0], rand_coeff(), rand_coeff());
        end

        // Directed: extreme coefficients at both ends, then extreme moduli,
        // including the values below two that act as two.
        send_request(FUNC_LOAD, 8'd0, COEFF_MIN, COEFF_MIN);
        send_request(FUNC_LOAD, 8'd255, COEFF_MAX, COEFF_MAX);
        send_request(FUNC_LOAD, 8'd1, -16'sd1, COEFF_MAX);
        send_request(FUNC_LOAD, 8'd254, COEFF_MIN, COEFF_MAX);
        send_request(FUNC_PROD, 8'd0, rand_coeff(), rand_coeff());
        send_request(FUNC_PROD, 8'd255, rand_coeff(), rand_coeff());
        send_request(FUNC_PROD, 8'd1, rand_coeff(), rand_coeff());
        send_request(FUNC_PROD, 8'd254, rand_coeff(), rand_coeff());
        send_request(FUNC_PROD, 8'd128, rand_coeff(), rand_coeff());
        change_modulus(MOD_MAX);
        send_request(FUNC_PROD, 8'd0, rand_coeff(), rand_coeff());
        send_request(FUNC_PROD, 8'd255, rand_coeff(), rand_coeff());
        change_modulus(MOD_MIN);
        send_request(FUNC_PROD, 8'd0, rand_coeff(), rand_coeff());
        send_request(FUNC_PROD, 8'd255, rand_coeff(), rand_coeff());
        change_modulus(15'd1);
        send_request(FUNC_PROD, 8'd3, rand_coeff(), rand_coeff());
        change_modulus(15'd0);
        send_request(FUNC_PROD, 8'd3, rand_coeff(), rand_coeff());

        // Random phases, each under its own modulus; loads and product requests mixed.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: phase_modulus = MOD_RESET;
                1: phase_modulus = MOD_MAX;
                4: phase_modulus = MOD_MIN;
                5: phase_modulus = 15'd7681;
                6: phase_modulus = MOD_W'($urandom_range(64, 3));
                7: phase_modulus = MOD_RESET;
                default: phase_modulus = MOD_W'($urandom_range(32767, 2));
            endcase
            change_modulus(phase_modulus);
            quiet <= (phase == 3);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                // Halfway through one phase the sender waits for every result.
                if (phase == 1 && n == PHASE_REQUESTS / 2) begin
                    wait_drained();
                end
                if ($urandom_range(99) < 35) begin
                    send_request(FUNC_PROD, INDEX_W'($urandom), rand_coeff(), rand_coeff());
                end else begin
                    send_request(FUNC_LOAD, INDEX_W'($urandom), rand_coeff(), rand_coeff());
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.pending() != 0) begin
            board.report_mismatch("expected coefficients left over at the end");
        end
        if (board.mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/ncpm_pkg.sv
src/negacyclic_poly_mul_mod_q_core.sv
test/tb_negacyclic_poly_mul_mod_q_core.sv
